// ===== rtl/tone_generator_with_biquad_top_assert.svh =====
// assertion macros shared by the tone generator modules
// they expect clk and arst_n in the scope where they are used
`ifndef TONE_GENERATOR_WITH_BIQUAD_TOP_ASSERT_SVH
`define TONE_GENERATOR_WITH_BIQUAD_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define TGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the following cycle
`define TGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tgb_pkg.sv =====
package tgb_pkg;

	localparam int IN_W       = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PHASE_W    = 32;
	localparam int AMP_W      = 15;
	localparam int COEF_W     = 18;
	localparam int STATE_W    = 40;

	localparam int unsigned ROUND_X = 16384;
	localparam int unsigned X_SHIFT = 15;
	localparam int unsigned ROUND_Y = 8192;
	localparam int unsigned Y_SHIFT = 14;

	localparam logic [PHASE_W-1:0] PULSE_LIMIT = 32'd429496730;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	localparam int MODE_PULSE_BIT = 0;
	localparam int MODE_FILT_BIT  = 1;

	localparam logic [AMP_W-1:0]         AMP_RESET = 15'h7FFF;
	localparam logic signed [COEF_W-1:0] B0_RESET  = 18'sd16384;

	// register indexes on the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AMP   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_B0    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_B1    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_B2    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_A1    = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_A2    = 3'd7;

	typedef struct packed {
		logic [1:0]                mode;
		logic [PHASE_W-1:0]        phase_step;
		logic [AMP_W-1:0]          amplitude;
		logic signed [COEF_W-1:0]  b0;
		logic signed [COEF_W-1:0]  b1;
		logic signed [COEF_W-1:0]  b2;
		logic signed [COEF_W-1:0]  a1;
		logic signed [COEF_W-1:0]  a2;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRC,
		ST_SCALE,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_F5,
		ST_PASS,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_AMP,
		MUL_B0,
		MUL_B1,
		MUL_B2,
		MUL_A1,
		MUL_A2
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic     start;
		logic     advance;
		logic     x_scale;
		logic     y_calc;
		logic     y_pass;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     s1_upd;
		logic     s2_upd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic gate;
		logic pulse;
		logic filt;
	} sts_t;

	// quarter-wave sine value, taylor series in unsigned q2.30, for table building only
	function automatic logic [63:0] quarter_sine(input int unsigned k,
			input int unsigned table_bits, input logic [63:0] full_scale);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = (64'(k) * HALF_PI_Q30) >> (table_bits - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * full_scale + (Q30_ONE >> 1)) >> 30;
		if (v > full_scale) begin
			v = full_scale;
		end
		return v;
	endfunction

endpackage

// ===== rtl/tgb_sine_rom.sv =====
module tgb_sine_rom #(
	parameter int TABLE_BITS   = 10,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic [TABLE_BITS-1:0]          idx,
	output logic signed [SAMPLE_WIDTH-1:0] val
);

	localparam int QUARTER = 1 << (TABLE_BITS - 2);
	localparam int AW      = TABLE_BITS - 1;
	localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

	logic [SAMPLE_WIDTH-2:0] rom_w [QUARTER+1];
	logic [AW-1:0]           addr;
	logic [SAMPLE_WIDTH-2:0] mag;
	logic signed [SAMPLE_WIDTH-1:0] val_q;

	// quarter wave plus the peak entry, the rest by symmetry
	for (genvar g = 0; g <= QUARTER; g++) begin : g_ent
		localparam logic [SAMPLE_WIDTH-2:0] VAL =
			(SAMPLE_WIDTH-1)'(tgb_pkg::quarter_sine(g, TABLE_BITS, FULL_SCALE));
		assign rom_w[g] = VAL;
	end

	always_comb begin
		if (idx[TABLE_BITS-2]) begin
			addr = AW'(QUARTER) - AW'(idx[TABLE_BITS-3:0]);
		end else begin
			addr = AW'(idx[TABLE_BITS-3:0]);
		end
		mag = rom_w[addr];
	end

	always_ff @(posedge clk) begin
		if (idx[TABLE_BITS-1]) begin
			val_q <= -$signed({1'b0, mag});
		end else begin
			val_q <= $signed({1'b0, mag});
		end
	end

	assign val = val_q;

endmodule

// ===== rtl/tgb_cfg.sv =====
module tgb_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [tgb_pkg::CFG_ADDR_W-1:0]      addr,
	input  logic [tgb_pkg::CFG_DATA_W-1:0]      wdata,
	output tgb_pkg::cfg_t                       cfg
);

	tgb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= '0;
			cfg_q.phase_step <= '0;
			cfg_q.amplitude  <= tgb_pkg::AMP_RESET;
			cfg_q.b0         <= tgb_pkg::B0_RESET;
			cfg_q.b1         <= '0;
			cfg_q.b2         <= '0;
			cfg_q.a1         <= '0;
			cfg_q.a2         <= '0;
		end else if (we) begin
			case (addr)
				tgb_pkg::REG_MODE: cfg_q.mode       <= wdata[1:0];
				tgb_pkg::REG_STEP: cfg_q.phase_step <= wdata[tgb_pkg::PHASE_W-1:0];
				tgb_pkg::REG_AMP:  cfg_q.amplitude  <= wdata[tgb_pkg::AMP_W-1:0];
				tgb_pkg::REG_B0:   cfg_q.b0         <= $signed(wdata[tgb_pkg::COEF_W-1:0]);
				tgb_pkg::REG_B1:   cfg_q.b1         <= $signed(wdata[tgb_pkg::COEF_W-1:0]);
				tgb_pkg::REG_B2:   cfg_q.b2         <= $signed(wdata[tgb_pkg::COEF_W-1:0]);
				tgb_pkg::REG_A1:   cfg_q.a1         <= $signed(wdata[tgb_pkg::COEF_W-1:0]);
				tgb_pkg::REG_A2:   cfg_q.a2         <= $signed(wdata[tgb_pkg::COEF_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tgb_dp.sv =====
module tgb_dp #(
	parameter int TABLE_BITS   = 10,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           gate,
	input  logic                           filter_clear,
	input  tgb_pkg::cfg_t                  cfg,
	input  tgb_pkg::cmd_t                  cmd,
	output tgb_pkg::sts_t                  sts,
	output logic signed [SAMPLE_WIDTH-1:0] sample
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int CW     = tgb_pkg::COEF_W;
	localparam int PW     = tgb_pkg::PHASE_W;
	localparam int STW    = tgb_pkg::STATE_W;
	localparam int PROD_W = SW + CW;
	localparam int ACC_W  = ((PROD_W > STW) ? PROD_W : STW) + 2;

	localparam logic signed [SW-1:0]     X_FULL = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]     X_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [STW-1:0]    ST_MAX = {1'b0, {(STW-1){1'b1}}};
	localparam logic signed [STW-1:0]    ST_MIN = {1'b1, {(STW-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  Y_MAX_A  = ACC_W'(X_FULL);
	localparam logic signed [ACC_W-1:0]  Y_MIN_A  = ACC_W'(X_MIN);
	localparam logic signed [ACC_W-1:0]  ST_MAX_A = ACC_W'(ST_MAX);
	localparam logic signed [ACC_W-1:0]  ST_MIN_A = ACC_W'(ST_MIN);
	localparam logic signed [PROD_W-1:0] X_RND  = PROD_W'(tgb_pkg::ROUND_X);
	localparam logic signed [ACC_W-1:0]  Y_RND  = ACC_W'(tgb_pkg::ROUND_Y);

	logic [PW-1:0]            phase_q;
	logic [PW-1:0]            phase_nx;
	logic                     gate_q;
	logic signed [STW-1:0]    s1_q;
	logic signed [STW-1:0]    s2_q;
	logic signed [SW-1:0]     tab_val;
	logic signed [SW-1:0]     x_q;
	logic signed [SW-1:0]     y_q;
	logic signed [SW-1:0]     sample_q;
	logic signed [SW-1:0]     mul_a;
	logic signed [CW-1:0]     mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] x_round;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  y_sh;
	logic signed [ACC_W-1:0]  s1_sum;
	logic signed [ACC_W-1:0]  s2_sum;
	logic signed [SW-1:0]     y_sat;
	logic signed [STW-1:0]    s1_sat;
	logic signed [STW-1:0]    s2_sat;
	logic signed [SW-1:0]     pulse_val;

	// table read follows the phase every cycle, so it holds the pre-advance value
	tgb_sine_rom #(
		.TABLE_BITS   (TABLE_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_rom (
		.clk (clk),
		.idx (phase_q[PW-1 -: TABLE_BITS]),
		.val (tab_val)
	);

	always_comb begin
		phase_nx  = phase_q + cfg.phase_step;
		pulse_val = (phase_nx < tgb_pkg::PULSE_LIMIT) ? X_FULL : '0;
		x_round   = (prod_q + X_RND) >>> tgb_pkg::X_SHIFT;

		y_sh = (ACC_W'(prod_q) + ACC_W'(s1_q) + Y_RND) >>> tgb_pkg::Y_SHIFT;
		if (y_sh > Y_MAX_A) begin
			y_sat = X_FULL;
		end else if (y_sh < Y_MIN_A) begin
			y_sat = X_MIN;
		end else begin
			y_sat = y_sh[SW-1:0];
		end

		s1_sum = acc_q + ACC_W'(s2_q);
		if (s1_sum > ST_MAX_A) begin
			s1_sat = ST_MAX;
		end else if (s1_sum < ST_MIN_A) begin
			s1_sat = ST_MIN;
		end else begin
			s1_sat = s1_sum[STW-1:0];
		end

		s2_sum = acc_q - ACC_W'(prod_q);
		if (s2_sum > ST_MAX_A) begin
			s2_sat = ST_MAX;
		end else if (s2_sum < ST_MIN_A) begin
			s2_sat = ST_MIN;
		end else begin
			s2_sat = s2_sum[STW-1:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			tgb_pkg::MUL_AMP: begin
				mul_a = tab_val;
				mul_b = $signed(CW'(cfg.amplitude));
			end
			tgb_pkg::MUL_B0: begin
				mul_a = x_q;
				mul_b = cfg.b0;
			end
			tgb_pkg::MUL_B1: begin
				mul_a = x_q;
				mul_b = cfg.b1;
			end
			tgb_pkg::MUL_B2: begin
				mul_a = x_q;
				mul_b = cfg.b2;
			end
			tgb_pkg::MUL_A1: begin
				mul_a = y_q;
				mul_b = cfg.a1;
			end
			tgb_pkg::MUL_A2: begin
				mul_a = y_q;
				mul_b = cfg.a2;
			end
			default: begin
				mul_a = x_q;
				mul_b = cfg.b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			gate_q  <= 1'b0;
			s1_q    <= '0;
			s2_q    <= '0;
		end else begin
			if (cmd.start) begin
				gate_q <= gate;
			end
			if (cmd.advance) begin
				phase_q <= phase_nx;
			end
			if (cmd.start && filter_clear) begin
				s1_q <= '0;
				s2_q <= '0;
			end else begin
				if (cmd.s1_upd) begin
					s1_q <= s1_sat;
				end
				if (cmd.s2_upd) begin
					s2_q <= s2_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.acc_op)
			tgb_pkg::ACC_LOAD: acc_q <= ACC_W'(prod_q);
			tgb_pkg::ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
			default: begin
			end
		endcase
		if (cmd.advance && cfg.mode[tgb_pkg::MODE_PULSE_BIT]) begin
			x_q <= pulse_val;
		end else if (cmd.x_scale) begin
			x_q <= x_round[SW-1:0];
		end
		// silence unless a later step overwrites it
		if (cmd.start) begin
			y_q <= '0;
		end else if (cmd.y_calc) begin
			y_q <= y_sat;
		end else if (cmd.y_pass) begin
			y_q <= x_q;
		end
		if (cmd.out_load) begin
			sample_q <= y_q;
		end
	end

	assign sts.gate  = gate_q;
	assign sts.pulse = cfg.mode[tgb_pkg::MODE_PULSE_BIT];
	assign sts.filt  = cfg.mode[tgb_pkg::MODE_FILT_BIT];
	assign sample    = sample_q;

`include "tone_generator_with_biquad_top_assert.svh"

	`TGB_ASSERT_NEXT(a_phase_hold, !cmd.advance, phase_q == $past(phase_q),
		"phase moved without an advance step")
	`TGB_ASSERT_NEXT(a_clear_states, cmd.start && filter_clear,
		s1_q == '0 && s2_q == '0, "filter state not cleared at item start")
	`TGB_ASSERT_NEXT(a_pulse_level, cmd.advance && cfg.mode[tgb_pkg::MODE_PULSE_BIT],
		x_q == '0 || x_q == X_FULL, "pulse sample neither zero nor full scale")

endmodule

// ===== rtl/tgb_ctrl.sv =====
module tgb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  tgb_pkg::sts_t sts,
	output tgb_pkg::cmd_t cmd
);

	tgb_pkg::state_t state_q;
	tgb_pkg::state_t state_nx;
	logic            out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tgb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = tgb_pkg::ST_SRC;
				end
			end
			tgb_pkg::ST_SRC: begin
				if (!sts.gate) begin
					state_nx = tgb_pkg::ST_OUT;
				end else if (!sts.pulse) begin
					state_nx = tgb_pkg::ST_SCALE;
				end else if (sts.filt) begin
					state_nx = tgb_pkg::ST_F0;
				end else begin
					state_nx = tgb_pkg::ST_PASS;
				end
			end
			tgb_pkg::ST_SCALE: begin
				state_nx = sts.filt ? tgb_pkg::ST_F0 : tgb_pkg::ST_PASS;
			end
			tgb_pkg::ST_F0: state_nx = tgb_pkg::ST_F1;
			tgb_pkg::ST_F1: state_nx = tgb_pkg::ST_F2;
			tgb_pkg::ST_F2: state_nx = tgb_pkg::ST_F3;
			tgb_pkg::ST_F3: state_nx = tgb_pkg::ST_F4;
			tgb_pkg::ST_F4: state_nx = tgb_pkg::ST_F5;
			tgb_pkg::ST_F5: state_nx = tgb_pkg::ST_OUT;
			tgb_pkg::ST_PASS: state_nx = tgb_pkg::ST_OUT;
			tgb_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_nx = tgb_pkg::ST_IDLE;
				end
			end
			default: state_nx = tgb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tgb_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			tgb_pkg::ST_SRC: begin
				cmd.advance = sts.gate;
				cmd.mul_en  = sts.gate && !sts.pulse;
				cmd.mul_sel = tgb_pkg::MUL_AMP;
			end
			tgb_pkg::ST_SCALE: cmd.x_scale = 1'b1;
			tgb_pkg::ST_F0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tgb_pkg::MUL_B0;
			end
			tgb_pkg::ST_F1: begin
				cmd.y_calc  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tgb_pkg::MUL_B1;
			end
			tgb_pkg::ST_F2: begin
				cmd.acc_op  = tgb_pkg::ACC_LOAD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tgb_pkg::MUL_A1;
			end
			tgb_pkg::ST_F3: begin
				cmd.acc_op  = tgb_pkg::ACC_SUB;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tgb_pkg::MUL_B2;
			end
			tgb_pkg::ST_F4: begin
				// s1 takes b1*x - a1*y + old s2 while b2*x moves into the accumulator
				cmd.s1_upd  = 1'b1;
				cmd.acc_op  = tgb_pkg::ACC_LOAD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tgb_pkg::MUL_A2;
			end
			tgb_pkg::ST_F5: cmd.s2_upd = 1'b1;
			tgb_pkg::ST_PASS: cmd.y_pass = 1'b1;
			tgb_pkg::ST_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tgb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`include "tone_generator_with_biquad_top_assert.svh"

	`TGB_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_q || out_ready,
		"output register overwritten before it was taken")
	`TGB_ASSERT_NEXT(a_accept_src, in_valid && in_ready, state_q == tgb_pkg::ST_SRC,
		"accepted item did not start the source step")
	`TGB_ASSERT_NOW(a_filter_path, state_q == tgb_pkg::ST_F0, sts.filt && sts.gate,
		"filter sequence entered with filter off or gate low")

endmodule

// ===== rtl/tone_generator_with_biquad_top.sv =====
// Tone generator with biquad: one item in per audio tick, one sample out. Bit 0 of the input
// tdata is gate, bit 1 filter_clear. A 32-bit phase accumulator drives either a quarter-wave
// sine table (scaled by amplitude) or a pulse that is high for the first tenth of a cycle,
// optionally followed by a transposed direct-form-II biquad with Q3.14 coefficients, saturated
// to SAMPLE_WIDTH bits. A gate-low item goes straight from source to output; a sine item adds
// a scale step; a gated item then takes the pass step, or F0 to F5 if filtered, to output.
// One multiplier forms the amplitude product and the five filter products one after the other.
// A new item is accepted once the previous result has moved into the output register, so
// the result may wait there while the next item is worked on. Registers must be written
// through the cfg port only between items; the block itself does not enforce this.
module tone_generator_with_biquad_top #(
	parameter int TABLE_BITS   = 10,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [tgb_pkg::IN_W-1:0]                  s_axis_tdata,  // gate, filter_clear
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample_out
	input  logic                                      cfg_we,
	input  logic [tgb_pkg::CFG_ADDR_W-1:0]            cfg_addr,
	input  logic [tgb_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	tgb_pkg::cfg_t               cfg;
	tgb_pkg::cmd_t               cmd;
	tgb_pkg::sts_t               sts;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	tgb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	tgb_dp #(
		.TABLE_BITS   (TABLE_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.gate         (s_axis_tdata[0]),
		.filter_clear (s_axis_tdata[1]),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample)
	);

	tgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	assign m_axis_tdata = OUT_W'($unsigned(sample));

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     SETTLE_CYCLES = 12;
	localparam longint SAMPLE_HI = 32767;
	localparam longint SAMPLE_LO = -32768;
	localparam longint SAT_HI = 64'sd549755813887;
	localparam longint SAT_LO = -64'sd549755813888;

	class tone_scoreboard;
		logic [1:0]  mode;
		logic [31:0] step;
		logic [14:0] amp;
		longint      b0, b1, b2, a1, a2;
		logic [31:0] phase;
		longint      s1, s2;
		int          sine_rom [1024];
		logic [15:0] expected [$];
		int          failures;
		int          n_checked;

		function new();
			int v;
			for (int i = 0; i < 1024; i++) begin
				v = (i & 256) ? quarter_wave(256 - (i & 255)) : quarter_wave(i & 255);
				sine_rom[i] = (i & 512) ? -v : v;
			end
			mode = '0;
			step = '0;
			amp = tgb_pkg::AMP_RESET;
			b0 = 16384;
			b1 = 0;
			b2 = 0;
			a1 = 0;
			a2 = 0;
			phase = '0;
			s1 = 0;
			s2 = 0;
			failures = 0;
			n_checked = 0;
		endfunction

		// taylor series of sin in unsigned q2.30, truncating products
		function int quarter_wave(int unsigned k);
			longint unsigned x, x2, t, s, v;
			x  = (longint'(k) * tgb_pkg::HALF_PI_Q30) >> 8;
			x2 = (x * x) >> 30;
			t  = tgb_pkg::Q30_ONE - x2 / 64'd72;
			t  = tgb_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = tgb_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = tgb_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			v  = (s * 64'd32767 + (tgb_pkg::Q30_ONE >> 1)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			return int'(v);
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(logic [tgb_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] d);
			case (idx)
				tgb_pkg::REG_MODE: mode = d[1:0];
				tgb_pkg::REG_STEP: step = d;
				tgb_pkg::REG_AMP:  amp = d[14:0];
				tgb_pkg::REG_B0:   b0 = longint'($signed(d[17:0]));
				tgb_pkg::REG_B1:   b1 = longint'($signed(d[17:0]));
				tgb_pkg::REG_B2:   b2 = longint'($signed(d[17:0]));
				tgb_pkg::REG_A1:   a1 = longint'($signed(d[17:0]));
				tgb_pkg::REG_A2:   a2 = longint'($signed(d[17:0]));
				default: ;
			endcase
		endfunction

		function void note_item(bit gate, bit clr);
			longint x, y;
			if (clr) begin
				s1 = 0;
				s2 = 0;
			end
			if (!gate) begin
				expected.push_back('0);
				return;
			end
			if (mode[tgb_pkg::MODE_PULSE_BIT]) begin
				phase += step;
				x = (phase < tgb_pkg::PULSE_LIMIT) ? SAMPLE_HI : 0;
			end else begin
				x = (longint'(sine_rom[phase[31:22]]) * longint'(amp) + 16384) >>> 15;
				phase += step;
			end
			if (mode[tgb_pkg::MODE_FILT_BIT]) begin
				y  = clip((b0 * x + s1 + 8192) >>> 14, SAMPLE_LO, SAMPLE_HI);
				s1 = clip(b1 * x - a1 * y + s2, SAT_LO, SAT_HI);
				s2 = clip(b2 * x - a2 * y, SAT_LO, SAT_HI);
			end else begin
				y = clip(x, SAMPLE_LO, SAMPLE_HI);
			end
			expected.push_back(y[15:0]);
		endfunction

		function void check_sample(logic [15:0] got);
			logic [15:0] want;
			n_checked++;
			if (expected.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("result %0d: sample %0d with none expected", n_checked,
						$signed(got));
				end
				return;
			end
			want = expected.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10) begin
					$display("result %0d: sample_out expected %0d, got %0d", n_checked,
						$signed(want), $signed(got));
				end
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [tgb_pkg::IN_W-1:0]       s_axis_tdata = '0;       // gate, filter_clear
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [15:0]                    m_axis_tdata;            // sample_out
	logic                           cfg_we = 1'b0;
	logic [tgb_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [tgb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	tone_scoreboard sb;
	bit             hold_req = 1'b0;
	bit             no_gaps = 1'b0;
	int             cycles = 0;

	tone_generator_with_biquad_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_sample(m_axis_tdata);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (299) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall > 0) begin
				m_axis_tready = 1'b0;
				stall--;
			end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
				m_axis_tready = 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(0, 2);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// all driving tasks start and end at a falling edge
	task automatic write_cfg(logic [tgb_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] d);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = d;
		@(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_item(bit gate, bit clr);
		s_axis_tdata = {{(tgb_pkg::IN_W - 2){1'b0}}, clr, gate};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(gate, clr);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int n;
		if (no_gaps || $urandom_range(0, 99) < 60) begin
			return;
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		s_axis_tvalid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// block is idle once every sample is back and the pipeline has drained
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (sb.expected.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] pad_coef(logic [17:0] c);
		return {14'($urandom()), c};
	endfunction

	task automatic directed();
		// reset settings: sine at phase zero gives silence
		send_item(1, 0);
		send_item(0, 0);
		send_item(0, 1);
		send_item(1, 1);
		settle();
		write_cfg(tgb_pkg::REG_MODE, 32'd1);
		write_cfg(tgb_pkg::REG_STEP, tgb_pkg::PULSE_LIMIT - 32'd1);
		send_item(1, 0);    // one below the pulse edge
		settle();
		write_cfg(tgb_pkg::REG_STEP, 32'd1);
		send_item(1, 0);    // on the edge
		settle();
		write_cfg(tgb_pkg::REG_STEP, 32'hFFFF_FFFF);
		send_item(1, 0);
		settle();
		write_cfg(tgb_pkg::REG_STEP, 32'd0 - (tgb_pkg::PULSE_LIMIT - 32'd1));
		send_item(1, 0);    // phase wraps to zero
		settle();
		write_cfg(tgb_pkg::REG_MODE, 32'd0);
		write_cfg(tgb_pkg::REG_STEP, 32'h4000_0000);
		repeat (4) send_item(1, 0);    // zero, peak, zero, trough
		send_item(0, 1);
		settle();
		write_cfg(tgb_pkg::REG_AMP, 32'hFFFF_8000);
		write_cfg(tgb_pkg::REG_STEP, 32'h0040_0000);
		send_item(1, 0);
		settle();
		// filtered pulse, output saturating both ways
		write_cfg(tgb_pkg::REG_MODE, 32'hFFFF_FFFF);
		write_cfg(tgb_pkg::REG_STEP, 32'd0);
		write_cfg(tgb_pkg::REG_B0, 32'hFFFC_FFFF);
		send_item(1, 1);
		settle();
		write_cfg(tgb_pkg::REG_B0, 32'h0002_0000);
		send_item(1, 0);
		settle();
		write_cfg(tgb_pkg::REG_B1, 32'h0001_FFFF);
		write_cfg(tgb_pkg::REG_A1, 32'h0002_0000);
		write_cfg(tgb_pkg::REG_B2, 32'h0002_0000);
		write_cfg(tgb_pkg::REG_A2, 32'h0001_FFFF);
		repeat (3) send_item(1, 0);
		send_item(1, 1);
		send_item(0, 1);
		settle();
		write_cfg(tgb_pkg::REG_MODE, 32'd2);
		write_cfg(tgb_pkg::REG_AMP, 32'd32767);
		write_cfg(tgb_pkg::REG_STEP, 32'h0123_4567);
		repeat (3) send_item(1, 0);
	endtask

	task automatic random_phase(int p);
		logic [1:0]  md;
		logic [31:0] stp;
		logic [14:0] amp;
		logic [17:0] c [5];
		settle();
		md = (p < 4) ? 2'(p) : 2'($urandom());
		if (p == 7) begin
			md[tgb_pkg::MODE_FILT_BIT] = 1'b1;
		end
		case (p)
			0: stp = $urandom();
			5: stp = 32'd0;
			6: stp = 32'hFFFF_FFFF;
			default: stp = $urandom_range(32'h0100_0000, 32'h2000_0000);
		endcase
		case (p % 3)
			0: amp = 15'h7FFF;
			1: amp = 15'($urandom());
			default: amp = 15'($urandom_range(0, 255));
		endcase
		case (p % 4)
			0: begin
				c[0] = 18'd16384;
				for (int k = 1; k < 5; k++) c[k] = '0;
			end
			1: begin
				// stable low-pass shape
				c[0] = 18'($urandom_range(500, 3000));
				c[1] = c[0] << 1;
				c[2] = c[0];
				c[3] = 18'(-int'($urandom_range(20000, 24000)));
				c[4] = 18'($urandom_range(9000, 12000));
			end
			2: for (int k = 0; k < 5; k++) c[k] = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
			default: for (int k = 0; k < 5; k++) c[k] = 18'($urandom());
		endcase
		write_cfg(tgb_pkg::REG_MODE, {30'($urandom()), md});
		write_cfg(tgb_pkg::REG_STEP, stp);
		write_cfg(tgb_pkg::REG_AMP, {17'($urandom()), amp});
		write_cfg(tgb_pkg::REG_B0, pad_coef(c[0]));
		write_cfg(tgb_pkg::REG_B1, pad_coef(c[1]));
		write_cfg(tgb_pkg::REG_B2, pad_coef(c[2]));
		write_cfg(tgb_pkg::REG_A1, pad_coef(c[3]));
		write_cfg(tgb_pkg::REG_A2, pad_coef(c[4]));
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 115; i++) begin
			if (p == 3 && i == 40) begin
				hold_req = 1'b1;
			end
			send_item($urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
			sender_gap();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed();
		for (int p = 0; p < 8; p++) begin
			random_phase(p);
		end
		s_axis_tvalid = 1'b0;
		while (sb.expected.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
